// File: rtl/core/dmd_pkg.sv
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types and constants of the binary64 multiply core.
// ----------------------------------------------------------------------------
package dmd_pkg;

    localparam int QDEPTH = 2;
    localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;

    typedef enum logic [1:0] {
        CLS_PASS,
        CLS_MUL,
        CLS_READ
    } cls_t;

    typedef struct packed {
        cls_t        cls;
        logic [63:0] pass_val;
        logic        sign;
        logic [52:0] ma;
        logic [52:0] mb;
        logic [12:0] eab;
    } qent_t;

    function automatic logic [5:0] lzc52(input logic [51:0] m);
        logic [5:0] n;
        logic       found;
        n = 6'd52;
        found = 1'b0;
        for (int i = 51; i >= 0; i--) begin
            if (!found && m[i]) begin
                n = 6'(51 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/core/dmd_front.sv
// ----------------------------------------------------------------------------
// dmd_front
// Accepts items, screens special operands, normalizes the significands.
// ----------------------------------------------------------------------------
module dmd_front import dmd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] number1,
    input  logic [63:0] number2,
    output logic        q_push,
    output qent_t       q_data,
    input  logic        q_full
);

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [5:0]  za, zb;
    logic [12:0] ea, eb;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        a_nan  = (number1[62:52] == 11'h7FF) && (number1[51:0] != '0);
        b_nan  = (number2[62:52] == 11'h7FF) && (number2[51:0] != '0);
        a_inf  = (number1[62:0] == 63'h7FF0000000000000);
        b_inf  = (number2[62:0] == 63'h7FF0000000000000);
        a_zero = (number1[62:0] == '0);
        b_zero = (number2[62:0] == '0);
        za = lzc52(number1[51:0]);
        zb = lzc52(number2[51:0]);
        q_data = '0;
        q_data.sign = number1[63] ^ number2[63];
        if (number1[62:52] == '0)
        begin
            q_data.ma = {1'b0, number1[51:0]} << (za + 6'd1);
            ea = 13'd1 - {7'd0, za} - 13'd1;
        end
        else
        begin
            q_data.ma = {1'b1, number1[51:0]};
            ea = {2'd0, number1[62:52]};
        end
        if (number2[62:52] == '0)
        begin
            q_data.mb = {1'b0, number2[51:0]} << (zb + 6'd1);
            eb = 13'd1 - {7'd0, zb} - 13'd1;
        end
        else
        begin
            q_data.mb = {1'b1, number2[51:0]};
            eb = {2'd0, number2[62:52]};
        end
        q_data.eab = ea + eb - 13'd1023;
        priority if (operation)
            q_data.cls = CLS_READ;
        else if (a_nan)
        begin
            q_data.cls = CLS_PASS;
            q_data.pass_val = number1 | 64'h0008000000000000;
        end
        else if (b_nan)
        begin
            q_data.cls = CLS_PASS;
            q_data.pass_val = number2 | 64'h0008000000000000;
        end
        else if ((a_inf || b_inf) && (a_zero || b_zero))
        begin
            q_data.cls = CLS_PASS;
            q_data.pass_val = DEFAULT_NAN;
        end
        else if (a_inf || b_inf)
        begin
            q_data.cls = CLS_PASS;
            q_data.pass_val = {q_data.sign, 11'h7FF, 52'd0};
        end
        else if (a_zero || b_zero)
        begin
            q_data.cls = CLS_PASS;
            q_data.pass_val = {q_data.sign, 63'd0};
        end
        else
            q_data.cls = CLS_MUL;
    end

endmodule

// File: rtl/core/dmd_queue.sv
// ----------------------------------------------------------------------------
// dmd_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module dmd_queue import dmd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t wdata,
    output logic  full,
    output logic  nonempty,
    input  logic  pop,
    output qent_t rdata
);

    qent_t      mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'(QDEPTH));
    assign nonempty = (cnt_reg != 2'd0);
    assign rdata    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        !nonempty |-> !pop) else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count");

endmodule

// File: rtl/core/dmd_back.sv
// ----------------------------------------------------------------------------
// dmd_back
// Multiplies the significands in four partial products of up to 27x27 bits, sums and
// normalizes them, rounds, keeps the last product and presents the result item.
// ----------------------------------------------------------------------------
module dmd_back import dmd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  qent_t       q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] product,
    output logic        status_ok
);

    logic        s1_v_reg, s2_v_reg;
    qent_t       s1_reg, s2_reg;
    logic [53:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0] sig_reg;
    logic [12:0] e_reg;
    logic        ovf_reg;
    logic        ov_reg;
    logic [63:0] res_reg, last_reg;
    logic        ok_reg;
    logic        s1_adv, s2_adv, s2_free, out_free;

    logic [105:0] prod;
    logic [12:0]  e_n;
    logic [63:0]  sig_n;
    logic [12:0]  e, e2;
    logic [63:0]  sh_sig;
    logic [12:0]  shamt;
    logic [53:0]  keep;
    logic [10:0]  rem;
    logic         rnd_up;
    logic [63:0]  mulres, fin;

    assign out_free  = !ov_reg || !out_stall;
    assign s2_adv    = s2_v_reg && out_free;
    assign s2_free   = !s2_v_reg || s2_adv;
    assign s1_adv    = s1_v_reg && s2_free;
    assign q_pop     = q_nonempty && (!s1_v_reg || s1_adv);
    assign out_valid = ov_reg;
    assign product   = res_reg;
    assign status_ok = ok_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg  <= q_data;
            p00_reg <= 54'(q_data.ma[26:0] * q_data.mb[26:0]);
            p01_reg <= 54'(q_data.ma[26:0] * q_data.mb[52:27]);
            p10_reg <= 54'(q_data.ma[52:27] * q_data.mb[26:0]);
            p11_reg <= 54'(q_data.ma[52:27] * q_data.mb[52:27]);
        end
    end

    always_comb
    begin
        prod = {52'd0, p00_reg} + ({52'd0, p01_reg} << 27) + ({52'd0, p10_reg} << 27)
             + ({52'd0, p11_reg} << 54);
        if (prod[105])
        begin
            e_n   = s1_reg.eab + 13'd1;
            sig_n = {prod[105:43], (prod[42:0] != '0)};
        end
        else
        begin
            e_n   = s1_reg.eab;
            sig_n = {prod[104:42], (prod[41:0] != '0)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_reg  <= s1_reg;
            sig_reg <= sig_n;
            e_reg   <= e_n;
            ovf_reg <= ($signed(e_n) >= 13'sd2047);
        end
    end

    always_comb
    begin
        e = e_reg;
        sh_sig = sig_reg;
        shamt = 13'd1 - e_reg;
        if ($signed(e_reg) <= 13'sd0)
        begin
            if (shamt >= 13'd64)
                sh_sig = {63'd0, (sig_reg != '0)};
            else
                sh_sig = (sig_reg >> shamt[5:0])
                       | {63'd0, ((sig_reg << (7'd64 - {1'b0, shamt[5:0]})) != '0)};
            e = '0;
        end
        rem    = sh_sig[10:0];
        rnd_up = (rem > 11'h400) || (rem == 11'h400 && sh_sig[11]);
        keep   = {1'b0, sh_sig[63:11]} + {53'd0, rnd_up};
        e2     = e + {12'd0, keep[53]};
        if (ovf_reg || e2 >= 13'd2047)
            mulres = {s2_reg.sign, 11'h7FF, 52'd0};
        else if (e == '0)
            mulres = {s2_reg.sign, 10'd0, keep[52:0]};
        else
            mulres = {s2_reg.sign, e2[10:0], keep[51:0]};
        unique case (s2_reg.cls)
            CLS_PASS: fin = s2_reg.pass_val;
            CLS_MUL:  fin = mulres;
            CLS_READ: fin = last_reg;
            default:  fin = last_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            res_reg <= fin;
            ok_reg  <= (s2_reg.cls != CLS_READ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
            last_reg <= '0;
        end
        else
        begin
            if (q_pop)
                s1_v_reg <= 1'b1;
            else if (s1_adv)
                s1_v_reg <= 1'b0;
            if (s1_adv)
                s2_v_reg <= 1'b1;
            else if (s2_adv)
                s2_v_reg <= 1'b0;
            if (s2_adv)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (s2_adv && s2_reg.cls != CLS_READ)
                last_reg <= fin;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> $stable(res_reg)) else $error("result moved");
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && s2_reg.cls == CLS_READ) |=> res_reg == $past(last_reg))
        else $error("read mismatch");
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s2_adv |=> ov_reg) else $error("lost result");

endmodule

// File: rtl/core/double_multiply_device_core.sv
// ----------------------------------------------------------------------------
// double_multiply_device_core
// IEEE-754 binary64 multiplier with kept last product.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// in        input      in_valid, in_stall, operation, number1, number2
// out       output     out_valid, out_stall, product, status_ok
// An item passes from acceptance to result through the queue, the partial
// products, sum and normalize, then round into the output register. One item
// per cycle is sustained while out_stall is low. Reset clears the queue, the
// pipeline valids and the kept product to +0.0. A stalled output backs up into
// the two-entry queue, and in_stall rises when that queue is full.
module double_multiply_device_core import dmd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] number1,
    input  logic [63:0] number2,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] product,
    output logic        status_ok
);

    logic  q_push, q_full, q_nonempty, q_pop;
    qent_t q_wdata, q_rdata;

    dmd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .number1(number1), .number2(number2),
        .q_push(q_push), .q_data(q_wdata), .q_full(q_full)
    );

    dmd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .full(q_full),
        .nonempty(q_nonempty), .pop(q_pop), .rdata(q_rdata)
    );

    dmd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_nonempty(q_nonempty), .q_data(q_rdata),
        .q_pop(q_pop), .out_valid(out_valid), .out_stall(out_stall),
        .product(product), .status_ok(status_ok)
    );

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the binary64 multiply core against a bit-exact integer predictor.
// A short table of directed items covers the IEEE-754 special cases and
// reads of the kept product. Random items with random idling on both sides
// follow. Every result is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb import dmd_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;
    localparam logic [63:0] POS_INF    = 64'h7FF0000000000000;
    localparam logic [63:0] QUIET_MASK = 64'h0008000000000000;

    typedef struct {
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
        bit          typed;
        logic [63:0] want;
    } access_t;

    typedef struct {
        logic [63:0] product;
        logic        status_ok;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [63:0] number1;
    logic [63:0] number2;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] product;
    logic        status_ok;

    bit          cur_typed;
    logic [63:0] cur_want;
    logic [63:0] kept_product;
    answer_t     pending_answers[$];
    access_t     access_table[$];
    bit          quiet;
    bit          failed;

    double_multiply_device_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .number1(number1),
        .number2(number2),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .product(product),
        .status_ok(status_ok)
    );

    always #5 clk = ~clk;

    function automatic bit is_nan(input logic [63:0] x);
        return x[62:52] == 11'h7FF && x[51:0] != 52'd0;
    endfunction

    function automatic logic [63:0] binary64_product(input logic [63:0] a, input logic [63:0] b);
        logic         sgn;
        logic [52:0]  ma;
        logic [52:0]  mb;
        int           ea;
        int           eb;
        int           e;
        int           sh;
        logic [105:0] p;
        logic [63:0]  sig;
        logic [53:0]  keep;
        logic [10:0]  rem;
        sgn = a[63] ^ b[63];
        if (is_nan(a))
            return a | QUIET_MASK;
        if (is_nan(b))
            return b | QUIET_MASK;
        if (a[62:0] == POS_INF[62:0] || b[62:0] == POS_INF[62:0])
        begin
            if (a[62:0] == 63'd0 || b[62:0] == 63'd0)
                return DEFAULT_NAN;
            return {sgn, POS_INF[62:0]};
        end
        if (a[62:0] == 63'd0 || b[62:0] == 63'd0)
            return {sgn, 63'd0};
        ea = int'(a[62:52]);
        ma = {1'b1, a[51:0]};
        if (ea == 0)
        begin
            ea = 1;
            ma = {1'b0, a[51:0]};
            while (!ma[52])
            begin
                ma = ma << 1;
                ea--;
            end
        end
        eb = int'(b[62:52]);
        mb = {1'b1, b[51:0]};
        if (eb == 0)
        begin
            eb = 1;
            mb = {1'b0, b[51:0]};
            while (!mb[52])
            begin
                mb = mb << 1;
                eb--;
            end
        end
        p = 106'(ma) * 106'(mb);
        e = ea + eb - 1023;
        if (p[105])
        begin
            e++;
            sig = p[105:42] | 64'(|p[41:0]);
        end
        else
            sig = p[104:41] | 64'(|p[40:0]);
        if (e >= 2047)
            return {sgn, POS_INF[62:0]};
        if (e <= 0)
        begin
            sh = 1 - e;
            if (sh >= 64)
                sig = 64'(sig != 64'd0);
            else
                sig = (sig >> sh) | 64'((sig << (64 - sh)) != 64'd0);
            e = 0;
        end
        keep = 54'(sig[63:11]);
        rem = sig[10:0];
        if (rem > 11'h400 || (rem == 11'h400 && keep[0]))
            keep++;
        if (e == 0)
            return {sgn, 9'd0, keep};
        if (keep[53])
        begin
            keep = keep >> 1;
            e++;
            if (e >= 2047)
                return {sgn, POS_INF[62:0]};
        end
        return {sgn, 11'(e), keep[51:0]};
    endfunction

    function automatic logic [63:0] random_operand();
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                case ($urandom_range(0, 5))
                    0: x[62:0] = 63'd0;
                    1: x[62:0] = POS_INF[62:0];
                    2: x[62:52] = 11'h7FF;
                    3: x[62:0] = 63'h7FEFFFFFFFFFFFFF;
                    4: x[62:0] = 63'h0010000000000000;
                    default: x[62:0] = 63'd1;
                endcase
                if (x[62:52] == 11'h7FF && x[51:0] == 52'd0 && $urandom_range(0, 1) == 1)
                    x[0] = 1'b1;
            end
            2, 3: x[62:52] = 11'd0;
            4, 5: x[30:0] = 31'd0;
            default: x[62:52] = 11'($urandom_range(1, 2046));
        endcase
        return x;
    endfunction

    task automatic add_row(input logic op, input logic [63:0] a, input logic [63:0] b,
                           input bit typed, input logic [63:0] want);
        access_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.want = want;
        access_table.push_back(r);
    endtask

    always @(posedge clk)
    begin
        answer_t ans;
        if (rst_n && in_valid && !in_stall)
        begin
            if (operation == OP_WRITE)
                kept_product = binary64_product(number1, number2);
            ans.product = cur_typed ? cur_want : kept_product;
            ans.status_ok = (operation == OP_WRITE);
            pending_answers.push_back(ans);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected item product=%h status_ok=%b", $time, product, status_ok);
                failed = 1'b1;
            end
            else
            begin
                ans = pending_answers.pop_front();
                if (product !== ans.product)
                begin
                    $display("%0t: product expected %h actual %h", $time, ans.product, product);
                    failed = 1'b1;
                end
                if (status_ok !== ans.status_ok)
                begin
                    $display("%0t: status_ok expected %b actual %b", $time, ans.status_ok, status_ok);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_stall = 1'b0;
        end
    end

    initial
    begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        access_t r;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_WRITE;
        number1 = 64'd0;
        number2 = 64'd0;
        cur_typed = 1'b0;
        cur_want = 64'd0;
        kept_product = 64'd0;
        quiet = 1'b0;
        failed = 1'b0;

        add_row(OP_READ, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'd0);
        add_row(OP_WRITE, 64'h3FF0000000000000, 64'h3FF0000000000000, 1'b1, 64'h3FF0000000000000);
        add_row(OP_WRITE, 64'h7FF0000000000001, 64'h3FF0000000000000, 1'b1, 64'h7FF8000000000001);
        add_row(OP_WRITE, 64'h3FF0000000000000, 64'hFFF0000000000002, 1'b1, 64'hFFF8000000000002);
        add_row(OP_WRITE, 64'h7FF4000000000000, 64'h7FF8000000000003, 1'b1, 64'h7FFC000000000000);
        add_row(OP_WRITE, 64'hFFFFFFFFFFFFFFFF, 64'd0, 1'b1, 64'hFFFFFFFFFFFFFFFF);
        add_row(OP_WRITE, 64'h7FF0000000000000, 64'h8000000000000000, 1'b1, DEFAULT_NAN);
        add_row(OP_WRITE, 64'hFFF0000000000000, 64'h4000000000000000, 1'b1, 64'hFFF0000000000000);
        add_row(OP_WRITE, 64'h8000000000000000, 64'h4014000000000000, 1'b1, 64'h8000000000000000);
        add_row(OP_WRITE, 64'd0, 64'd0, 1'b1, 64'd0);
        add_row(OP_WRITE, 64'h7FEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1'b1, POS_INF);
        add_row(OP_WRITE, 64'hFFEFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 1'b1, 64'hFFF0000000000000);
        add_row(OP_WRITE, 64'h0000000000000001, 64'h3FE0000000000000, 1'b1, 64'd0);
        add_row(OP_WRITE, 64'h0000000000000003, 64'h3FE0000000000000, 1'b0, 64'd0);
        add_row(OP_WRITE, 64'h0000000000000001, 64'h0000000000000001, 1'b0, 64'd0);
        add_row(OP_WRITE, 64'h0000000000000001, 64'h4330000000000000, 1'b1, 64'h0010000000000000);
        add_row(OP_WRITE, 64'h000FFFFFFFFFFFFF, 64'h3FF0000000000000, 1'b1, 64'h000FFFFFFFFFFFFF);
        add_row(OP_WRITE, 64'h0010000000000000, 64'h3FEFFFFFFFFFFFFF, 1'b0, 64'd0);
        add_row(OP_WRITE, 64'h3FF0000000000001, 64'h3FF0000000000001, 1'b0, 64'd0);
        add_row(OP_WRITE, 64'h4005555555555555, 64'hBFD5555555555555, 1'b0, 64'd0);
        add_row(OP_READ, 64'd0, 64'd0, 1'b0, 64'd0);
        for (int i = 0; i < 450; i++)
            add_row(($urandom_range(0, 6) == 0) ? OP_READ : OP_WRITE,
                    random_operand(), random_operand(), 1'b0, 64'd0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < access_table.size(); i++)
        begin
            r = access_table[i];
            quiet = (i > access_table.size() - 80);
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
                @(negedge clk);
            end
            in_valid = 1'b1;
            operation = r.op;
            number1 = r.a;
            number2 = r.b;
            cur_typed = r.typed;
            cur_want = r.want;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed && pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dmd_pkg.sv
rtl/core/dmd_front.sv
rtl/core/dmd_queue.sv
rtl/core/dmd_back.sv
rtl/core/double_multiply_device_core.sv
verif/tb.sv
